FILE: rtl/huffman_code_bit_packer_unit_macros.svh
`ifndef HUFFMAN_CODE_BIT_PACKER_UNIT_MACROS_SVH
`define HUFFMAN_CODE_BIT_PACKER_UNIT_MACROS_SVH

// same-cycle implication, checked while out of reset
`define HCBP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked while out of reset
`define HCBP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/hcbp_pkg.sv
`default_nettype none

package hcbp_pkg;

  localparam int ACC_W  = 40;
  localparam int CODE_W = 32;
  localparam int LEN_W  = 6;
  localparam int SYM_W  = 8;
  localparam int BYTE_W = 8;

  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_ENCODE = 2'd1;
  localparam logic [1:0] CMD_FLUSH  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_EMIT,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic               wr;
    logic               rd;
    logic [SYM_W-1:0]   sym;
    logic [CODE_W-1:0]  word;
    logic [LEN_W-1:0]   len;
  } tbl_req_t;

endpackage

`default_nettype wire

FILE: rtl/hcbp_table.sv
`default_nettype none

module hcbp_table #(
  parameter int MAX_CODE_LEN = 32,
  parameter int NUM_SYMBOLS  = 256
) (
  input  wire logic                           clk,
  input  wire hcbp_pkg::tbl_req_t             req,
  output logic [hcbp_pkg::CODE_W-1:0]         rd_code,
  output logic [hcbp_pkg::LEN_W-1:0]          rd_len
);

  localparam int AW = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int EW = hcbp_pkg::CODE_W + hcbp_pkg::LEN_W;

  logic [EW-1:0]                    mem [NUM_SYMBOLS];
  logic [hcbp_pkg::LEN_W-1:0]       len_sat;
  logic [hcbp_pkg::CODE_W-1:0]      mask;
  logic [EW-1:0]                    rd_data;

  // saturate length, keep only the top len bits of the word
  always_comb begin
    len_sat = (req.len > hcbp_pkg::LEN_W'(MAX_CODE_LEN)) ?
              hcbp_pkg::LEN_W'(MAX_CODE_LEN) : req.len;
    mask    = ~({hcbp_pkg::CODE_W{1'b1}} >> len_sat);
  end

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.sym[AW-1:0]] <= {req.word & mask, len_sat};
    end
    if (req.rd) begin
      rd_data <= mem[req.sym[AW-1:0]];
    end
  end

  assign rd_code = rd_data[EW-1:hcbp_pkg::LEN_W];
  assign rd_len  = rd_data[hcbp_pkg::LEN_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/huffman_code_bit_packer_unit.sv
// Steps: a table write is taken in ST_IDLE; an encode is accepted in ST_IDLE, reads the table,
// merges the code in ST_LOOK and sends its bytes (0..4) from ST_EMIT, one per out_ready handshake.
// A flush with bits held sends the partial byte from ST_FLUSH. One transaction is processed at a time.
// Reset: synchronous, clears accumulator and bit count; table contents undefined until written.
`default_nettype none

module huffman_code_bit_packer_unit #(
  parameter int MAX_CODE_LEN = 32,
  parameter int NUM_SYMBOLS  = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    command,
  input  wire logic [hcbp_pkg::SYM_W-1:0]    symbol,
  input  wire logic [hcbp_pkg::CODE_W-1:0]   code_word,
  input  wire logic [hcbp_pkg::LEN_W-1:0]    code_length,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [hcbp_pkg::BYTE_W-1:0]        out_byte,
  output logic                               last
);

  hcbp_pkg::state_t                  state, state_next;
  logic [hcbp_pkg::ACC_W-1:0]        acc, acc_next;
  logic [hcbp_pkg::LEN_W-1:0]        held, held_next;
  logic [hcbp_pkg::LEN_W-1:0]        held_sum;
  logic [hcbp_pkg::ACC_W-1:0]        acc_ins;
  logic [hcbp_pkg::CODE_W-1:0]       rd_code;
  logic [hcbp_pkg::LEN_W-1:0]        rd_len;
  hcbp_pkg::tbl_req_t                req;
  logic                              in_fire;
  logic                              sym_ok;

  assign in_fire = in_valid && in_ready;
  assign sym_ok  = {1'b0, symbol} < (hcbp_pkg::SYM_W + 1)'(NUM_SYMBOLS);

  always_comb begin
    req.wr   = in_fire && (command == hcbp_pkg::CMD_WRITE) && sym_ok;
    req.rd   = in_fire && (command == hcbp_pkg::CMD_ENCODE) && sym_ok;
    req.sym  = symbol;
    req.word = code_word;
    req.len  = code_length;
  end

  hcbp_table #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .NUM_SYMBOLS  (NUM_SYMBOLS)
  ) u_table (
    .clk     (clk),
    .req     (req),
    .rd_code (rd_code),
    .rd_len  (rd_len)
  );

  assign acc_ins  = {rd_code, {hcbp_pkg::BYTE_W{1'b0}}} >> held[2:0];
  assign held_sum = {3'b000, held[2:0]} + rd_len;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      hcbp_pkg::ST_IDLE: begin
        if (in_fire && (command == hcbp_pkg::CMD_ENCODE) && sym_ok) begin
          state_next = hcbp_pkg::ST_LOOK;
        end else if (in_fire && (command == hcbp_pkg::CMD_FLUSH) && (held != '0)) begin
          state_next = hcbp_pkg::ST_FLUSH;
        end
      end
      hcbp_pkg::ST_LOOK: begin
        state_next = (held_sum >= hcbp_pkg::LEN_W'(8)) ? hcbp_pkg::ST_EMIT : hcbp_pkg::ST_IDLE;
      end
      hcbp_pkg::ST_EMIT: begin
        if (out_ready && (held < hcbp_pkg::LEN_W'(16))) begin
          state_next = hcbp_pkg::ST_IDLE;
        end
      end
      hcbp_pkg::ST_FLUSH: begin
        if (out_ready) begin
          state_next = hcbp_pkg::ST_IDLE;
        end
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    last      = 1'b0;
    unique case (state)
      hcbp_pkg::ST_IDLE:  in_ready = 1'b1;
      hcbp_pkg::ST_LOOK:  in_ready = 1'b0;
      hcbp_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        last      = held < hcbp_pkg::LEN_W'(16);
      end
      hcbp_pkg::ST_FLUSH: begin
        out_valid = 1'b1;
        last      = 1'b1;
      end
    endcase
  end

  assign out_byte = acc[hcbp_pkg::ACC_W-1 -: hcbp_pkg::BYTE_W];

  // accumulator datapath
  always_comb begin
    acc_next  = acc;
    held_next = held;
    unique case (state)
      hcbp_pkg::ST_IDLE: begin
        // a flush with bits held keeps them until the partial byte is sent
        if (in_fire && (command == hcbp_pkg::CMD_FLUSH) && (held == '0)) begin
          acc_next  = '0;
          held_next = '0;
        end
      end
      hcbp_pkg::ST_LOOK: begin
        acc_next  = acc | acc_ins;
        held_next = held_sum;
      end
      hcbp_pkg::ST_EMIT: begin
        if (out_ready) begin
          acc_next  = acc << hcbp_pkg::BYTE_W;
          held_next = held - hcbp_pkg::LEN_W'(8);
        end
      end
      hcbp_pkg::ST_FLUSH: begin
        if (out_ready) begin
          acc_next  = '0;
          held_next = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hcbp_pkg::ST_IDLE;
      acc   <= '0;
      held  <= '0;
    end else begin
      state <= state_next;
      acc   <= acc_next;
      held  <= held_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/hcbp_checker.sv
`default_nettype none
`include "huffman_code_bit_packer_unit_macros.svh"

module hcbp_checker #(
  parameter int NUM_SYMBOLS = 256
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic [1:0]                    command,
  input wire logic [hcbp_pkg::SYM_W-1:0]    symbol,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [hcbp_pkg::BYTE_W-1:0]   out_byte,
  input wire logic                          last
);

  logic enc_fire;
  logic wr_fire;

  assign enc_fire = in_valid && in_ready && (command == hcbp_pkg::CMD_ENCODE) &&
                    ({1'b0, symbol} < (hcbp_pkg::SYM_W + 1)'(NUM_SYMBOLS));
  assign wr_fire  = in_valid && in_ready && (command == hcbp_pkg::CMD_WRITE);

  `HCBP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(last), "output changed while stalled")
  `HCBP_ASSERT_NOW(a_one_at_a_time, clk, rst, out_valid, !in_ready, "input taken while result pending")
  `HCBP_ASSERT_NEXT(a_enc_lookup, clk, rst, enc_fire, !in_ready && !out_valid, "encode skipped table read cycle")
  `HCBP_ASSERT_NEXT(a_write_quiet, clk, rst, wr_fire, in_ready && !out_valid, "table write produced output")

endmodule

bind huffman_code_bit_packer_unit hcbp_checker #(.NUM_SYMBOLS(NUM_SYMBOLS)) u_hcbp_checker (.*);

`default_nettype wire

FILE: tb/tb.sv
`default_nettype none

module tb;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int MAX_LEN = 32;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER = 70;
  localparam int MAX_SHOWN = 10;
  localparam int RANDOM_ITEMS = 108;

  typedef struct {
    logic [1:0]                  cmd;
    logic [hcbp_pkg::SYM_W-1:0]  sym;
    logic [hcbp_pkg::CODE_W-1:0] word;
    logic [hcbp_pkg::LEN_W-1:0]  len;
    int unsigned                 gap;
  } pack_cmd_t;

  typedef struct {
    logic [hcbp_pkg::BYTE_W-1:0] data;
    logic                        last;
  } packed_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic [1:0] command = hcbp_pkg::CMD_WRITE;
  logic [hcbp_pkg::SYM_W-1:0] symbol = '0;
  logic [hcbp_pkg::CODE_W-1:0] code_word = '0;
  logic [hcbp_pkg::LEN_W-1:0] code_length = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  logic [hcbp_pkg::BYTE_W-1:0] out_byte;
  logic last;

  huffman_code_bit_packer_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .symbol     (symbol),
    .code_word  (code_word),
    .code_length(code_length),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .last       (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [hcbp_pkg::CODE_W-1:0] tbl_code [256];
  logic [hcbp_pkg::LEN_W-1:0]  tbl_len  [256];
  logic [hcbp_pkg::ACC_W-1:0]  acc_bits = '0;
  int unsigned                 acc_count = 0;

  pack_cmd_t    pending_cmds [$];
  packed_byte_t expected_bytes [$];

  // stimulus bookkeeping
  bit          sym_known [256];
  int unsigned known_syms [$];

  pack_cmd_t    cur_cmd;
  packed_byte_t want;
  int unsigned  gap_left = 0;
  int unsigned  stall_left = 0;
  int unsigned  hold_left = 0;
  bit           hold_done = 1'b0;
  int unsigned  accepted_cnt = 0;
  int unsigned  mismatches = 0;
  int unsigned  cycle_cnt = 0;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(25, 70);
  endfunction

  task automatic predict_packed_bytes(input pack_cmd_t t);
    int unsigned l;
    int unsigned n;
    logic [hcbp_pkg::CODE_W-1:0] mask;
    logic [hcbp_pkg::ACC_W-1:0] shifted;
    packed_byte_t b;
    case (t.cmd)
      hcbp_pkg::CMD_WRITE: begin
        l = (t.len > MAX_LEN) ? MAX_LEN : t.len;
        mask = '1;
        mask = (l == 0) ? '0 : (mask << (hcbp_pkg::CODE_W - l));
        tbl_code[t.sym] = t.word & mask;
        tbl_len[t.sym] = hcbp_pkg::LEN_W'(l);
      end
      hcbp_pkg::CMD_ENCODE: begin
        shifted = {tbl_code[t.sym], 8'h00};
        acc_bits = acc_bits | (shifted >> (acc_count & 7));
        acc_count = (acc_count & 7) + tbl_len[t.sym];
        n = 0;
        while (acc_count >= 8 && n < 4) begin
          b.data = acc_bits[hcbp_pkg::ACC_W-1 -: hcbp_pkg::BYTE_W];
          b.last = (acc_count < 16) || (n == 3);
          expected_bytes.push_back(b);
          acc_bits = acc_bits << 8;
          acc_count -= 8;
          n++;
        end
      end
      hcbp_pkg::CMD_FLUSH: begin
        if (acc_count != 0) begin
          b.data = acc_bits[hcbp_pkg::ACC_W-1 -: hcbp_pkg::BYTE_W];
          b.last = 1'b1;
          expected_bytes.push_back(b);
        end
        acc_bits = '0;
        acc_count = 0;
      end
      default: ;
    endcase
  endtask

  task automatic add_cmd(input logic [1:0] cmd, input int unsigned sym,
                         input logic [hcbp_pkg::CODE_W-1:0] word, input int unsigned len,
                         input int unsigned gap);
    pack_cmd_t t;
    t.cmd = cmd;
    t.sym = hcbp_pkg::SYM_W'(sym);
    t.word = word;
    t.len = hcbp_pkg::LEN_W'(len);
    t.gap = gap;
    pending_cmds.push_back(t);
    if (cmd == hcbp_pkg::CMD_WRITE && !sym_known[sym]) begin
      sym_known[sym] = 1'b1;
      known_syms.push_back(sym);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_packed_bytes(cur_cmd);
        accepted_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          cur_cmd = pending_cmds.pop_front();
          command <= cur_cmd.cmd;
          symbol <= cur_cmd.sym;
          code_word <= cur_cmd.word;
          code_length <= cur_cmd.len;
          in_valid <= 1'b1;
          gap_left = cur_cmd.gap;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so the block backs up into its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && accepted_cnt >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done = 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("unexpected transaction: out_byte %h last %b", out_byte, last);
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want.data || last !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
              $display("mismatch: expected out_byte %h last %b, got out_byte %h last %b",
                       want.data, want.last, out_byte, last);
          end
        end
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        // new receiver stalls are picked only outside every fourth cycle_cnt window
        if ((cycle_cnt / 300) % 4 != 0)
          stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned r;
    int unsigned lr;
    int unsigned len;

    // directed
    add_cmd(hcbp_pkg::CMD_WRITE, 0, 32'hFFFF_FFFF, 32, 0);
    add_cmd(hcbp_pkg::CMD_WRITE, 255, 32'hFFFF_FFFF, 63, 0);
    add_cmd(hcbp_pkg::CMD_WRITE, 1, 32'hA5A5_A5A5, 5, 0);
    add_cmd(hcbp_pkg::CMD_WRITE, 2, 32'h8000_0000, 1, 0);
    add_cmd(hcbp_pkg::CMD_WRITE, 3, $urandom, 0, 0);
    add_cmd(hcbp_pkg::CMD_WRITE, 4, 32'h5A00_0000, 8, 0);
    add_cmd(hcbp_pkg::CMD_WRITE, 128, 32'h1234_5678, 33, 0);
    add_cmd(hcbp_pkg::CMD_WRITE, 127, 32'h0000_0000, 32, 0);
    add_cmd(hcbp_pkg::CMD_FLUSH, 0, 32'h0, 0, 0);
    add_cmd(hcbp_pkg::CMD_ENCODE, 1, 32'h0, 0, 0);
    add_cmd(hcbp_pkg::CMD_ENCODE, 0, 32'hFFFF_FFFF, 63, 0);
    add_cmd(hcbp_pkg::CMD_ENCODE, 255, 32'h0, 0, 0);
    add_cmd(hcbp_pkg::CMD_ENCODE, 3, 32'h0, 0, 0);
    add_cmd(hcbp_pkg::CMD_FLUSH, 255, 32'hFFFF_FFFF, 63, 0);
    add_cmd(hcbp_pkg::CMD_FLUSH, 0, 32'h0, 0, 0);
    add_cmd(CMD_UNUSED, 255, 32'hFFFF_FFFF, 63, 0);
    add_cmd(hcbp_pkg::CMD_ENCODE, 4, 32'h0, 0, 0);
    add_cmd(hcbp_pkg::CMD_ENCODE, 2, 32'h0, 0, 0);
    add_cmd(hcbp_pkg::CMD_ENCODE, 127, 32'h0, 0, 0);
    add_cmd(hcbp_pkg::CMD_ENCODE, 128, 32'h0, 0, 0);
    add_cmd(hcbp_pkg::CMD_FLUSH, 0, 32'h0, 0, 0);
    add_cmd(CMD_UNUSED, 0, 32'h0, 0, 0);

    // random
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 18 || known_syms.size() == 0) begin
        lr = $urandom_range(0, 99);
        if (lr < 5) len = 0;
        else if (lr < 70) len = $urandom_range(1, 12);
        else if (lr < 90) len = $urandom_range(13, 32);
        else len = $urandom_range(33, 63);
        add_cmd(hcbp_pkg::CMD_WRITE, $urandom_range(0, 255), $urandom, len,
                (i >= 30 && i < 55) ? 0 : pick_gap());
      end else if (r < 83) begin
        add_cmd(hcbp_pkg::CMD_ENCODE, known_syms[$urandom_range(0, known_syms.size() - 1)],
                $urandom, $urandom_range(0, 63), (i >= 30 && i < 55) ? 0 : pick_gap());
      end else if (r < 95) begin
        add_cmd(hcbp_pkg::CMD_FLUSH, $urandom_range(0, 255), $urandom, $urandom_range(0, 63),
                (i >= 30 && i < 55) ? 0 : pick_gap());
      end else begin
        add_cmd(CMD_UNUSED, $urandom_range(0, 255), $urandom, $urandom_range(0, 63),
                (i >= 30 && i < 55) ? 0 : pick_gap());
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || in_valid) @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d transactions outstanding", mismatches,
               expected_bytes.size());
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+rtl
rtl/hcbp_pkg.sv
rtl/hcbp_table.sv
rtl/huffman_code_bit_packer_unit.sv
rtl/hcbp_checker.sv
tb/tb.sv
